### rtl/tracker_sample_voice_macros.svh
// ---------------------------------------------------------------------------
// tracker_sample_voice assertion macros
// shared concurrent assertion forms for the voice checker
// ---------------------------------------------------------------------------
`ifndef TRACKER_SAMPLE_VOICE_MACROS_SVH
`define TRACKER_SAMPLE_VOICE_MACROS_SVH

// same-cycle implication
`define TSV_ASSERT_NOW(lbl, ck, dis, a, c) \
	lbl: assert property (@(posedge ck) disable iff (dis) (a) |-> (c)) \
		else $error("tsv assertion failed");

// next-cycle implication
`define TSV_ASSERT_NEXT(lbl, ck, dis, a, c) \
	lbl: assert property (@(posedge ck) disable iff (dis) (a) |=> (c)) \
		else $error("tsv assertion failed");

`endif

### rtl/tsv_pkg.sv
// ---------------------------------------------------------------------------
// tsv_pkg
// types and constants shared by the sample voice modules
// ---------------------------------------------------------------------------
package tsv_pkg;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_SET  = 2'd2;

	localparam logic [2:0] REG_PHASE_STEP    = 3'd0;
	localparam logic [2:0] REG_SAMPLE_LENGTH = 3'd1;
	localparam logic [2:0] REG_LOOP_START    = 3'd2;
	localparam logic [2:0] REG_LOOP_END      = 3'd3;
	localparam logic [2:0] REG_LOOP_FLAGS    = 3'd4;
	localparam logic [2:0] REG_WIDE_SAMPLES  = 3'd5;
	localparam logic [2:0] REG_CHAN_VOLUME   = 3'd6;
	localparam logic [2:0] REG_INST_VOLUME   = 3'd7;

	// power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [23:0] phase_step;
		logic [14:0] sample_length;
		logic [14:0] loop_start;
		logic [14:0] loop_end;
		logic [1:0]  loop_flags;
		logic        wide_samples;
		logic [6:0]  channel_volume;
		logic [6:0]  instrument_volume;
	} cfg_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_PLAY = 1'b1
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        in_range;
		logic [14:0] index;
		logic [15:0] data;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

### rtl/tracker_sample_voice.sv
// ---------------------------------------------------------------------------
// tracker_sample_voice
// one wavetable voice with sustain loop and volume scaling
// ---------------------------------------------------------------------------
// Takes one item per clock while not stalled. The play position is updated
// in the front end by compares, selects and one add per tick, which sets the
// single-cycle item rate; every in-range load and every playing tick costs
// one access of the single-port sample memory in the back end, again one per
// clock while results are not stalled. A played sample then passes through
// the read, product and result registers (memory read, multiply, scale and
// saturate). A four-entry queue keeps input flowing while results stall.
// ---------------------------------------------------------------------------
module tracker_sample_voice #(
	parameter int SAMPLE_DEPTH       = 16384,
	parameter int POSITION_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         mode,
	input  logic [13:0]        load_address,
	input  logic signed [15:0] load_data,
	input  logic [14:0]        new_position,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] sample_out,
	output logic [13:0]        sample_index
);
	import tsv_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;
	logic       push;
	logic       pop;
	entry_t     push_entry;
	entry_t     head;
	qstat_t     qstat;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step        <= 24'd0;
			cfg_q.sample_length     <= 15'd0;
			cfg_q.loop_start        <= 15'd0;
			cfg_q.loop_end          <= 15'd0;
			cfg_q.loop_flags        <= 2'd0;
			cfg_q.wide_samples      <= 1'b1;
			cfg_q.channel_volume    <= 7'd0;
			cfg_q.instrument_volume <= 7'd64;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PHASE_STEP:    cfg_q.phase_step        <= pwdata[23:0];
				REG_SAMPLE_LENGTH: cfg_q.sample_length     <= pwdata[14:0];
				REG_LOOP_START:    cfg_q.loop_start        <= pwdata[14:0];
				REG_LOOP_END:      cfg_q.loop_end          <= pwdata[14:0];
				REG_LOOP_FLAGS:    cfg_q.loop_flags        <= pwdata[1:0];
				REG_WIDE_SAMPLES:  cfg_q.wide_samples      <= pwdata[0];
				REG_CHAN_VOLUME:   cfg_q.channel_volume    <= pwdata[6:0];
				REG_INST_VOLUME:   cfg_q.instrument_volume <= pwdata[6:0];
				default:           cfg_q                   <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PHASE_STEP:    prdata = {8'd0, cfg_q.phase_step};
			REG_SAMPLE_LENGTH: prdata = {17'd0, cfg_q.sample_length};
			REG_LOOP_START:    prdata = {17'd0, cfg_q.loop_start};
			REG_LOOP_END:      prdata = {17'd0, cfg_q.loop_end};
			REG_LOOP_FLAGS:    prdata = {30'd0, cfg_q.loop_flags};
			REG_WIDE_SAMPLES:  prdata = {31'd0, cfg_q.wide_samples};
			REG_CHAN_VOLUME:   prdata = {25'd0, cfg_q.channel_volume};
			REG_INST_VOLUME:   prdata = {25'd0, cfg_q.instrument_volume};
			default:           prdata = 32'd0;
		endcase
	end

	tsv_front #(
		.SAMPLE_DEPTH       (SAMPLE_DEPTH),
		.POSITION_FRAC_BITS (POSITION_FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.load_address (load_address),
		.load_data    (load_data),
		.new_position (new_position),
		.qstat        (qstat),
		.push         (push),
		.push_entry   (push_entry)
	);

	tsv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	tsv_back #(
		.SAMPLE_DEPTH (SAMPLE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sample_out   (sample_out),
		.sample_index (sample_index)
	);

endmodule

### rtl/tsv_front.sv
// ---------------------------------------------------------------------------
// tsv_front
// accepts items, keeps the play position and classifies loads and playing
// ticks into memory operations for the back end
// ---------------------------------------------------------------------------
module tsv_front #(
	parameter int SAMPLE_DEPTH       = 16384,
	parameter int POSITION_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tsv_pkg::cfg_t       cfg,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [1:0]          mode,
	input  logic [13:0]         load_address,
	input  logic signed [15:0]  load_data,
	input  logic [14:0]         new_position,
	input  tsv_pkg::qstat_t     qstat,
	output logic                push,
	output tsv_pkg::entry_t     push_entry
);
	import tsv_pkg::*;

	function automatic logic [31:0] to_pos(input logic [14:0] x);
		logic [31:0] w;
		w = {17'd0, x};
		return w << POSITION_FRAC_BITS;
	endfunction

	logic [31:0] pos_q;
	logic [31:0] pos_d;
	logic        accept;
	logic        active;
	logic [31:0] idx0;
	logic [31:0] idx1;
	logic [31:0] pos1;
	logic        play;
	logic [14:0] play_idx;
	logic [31:0] play_base;
	logic [31:0] tick_pos;
	logic        load_ok;
	logic        play_ok;

	assign item_stall = qstat.full;
	assign accept     = item_valid && !qstat.full;

	assign active = (cfg.phase_step != 24'd0) && (cfg.channel_volume != 7'd0)
		&& (cfg.sample_length != 15'd0);
	assign load_ok = {18'd0, load_address} < 32'(SAMPLE_DEPTH);

	always_comb begin
		idx0 = pos_q >> POSITION_FRAC_BITS;
		if (cfg.loop_flags[0] && (idx0 >= {17'd0, cfg.loop_end})) begin
			pos1 = to_pos(cfg.loop_start);
			idx1 = {17'd0, cfg.loop_start};
		end else begin
			pos1 = pos_q;
			idx1 = idx0;
		end
		play      = 1'b1;
		play_base = pos1;
		play_idx  = idx1[14:0];
		tick_pos  = pos1;
		if (idx1 >= {17'd0, cfg.sample_length}) begin
			if (cfg.loop_flags[1]) begin
				play_base = 32'd0;
				play_idx  = 15'd0;
			end else begin
				play     = 1'b0;
				tick_pos = to_pos(cfg.sample_length);
			end
		end
		if (play) begin
			tick_pos = play_base + {8'd0, cfg.phase_step};
		end
	end

	assign play_ok = {17'd0, play_idx} < 32'(SAMPLE_DEPTH);

	always_comb begin
		pos_d               = pos_q;
		push                = 1'b0;
		push_entry.op       = OP_LOAD;
		push_entry.in_range = load_ok;
		push_entry.index    = {1'b0, load_address};
		push_entry.data     = load_data;
		unique case (mode)
			MODE_LOAD: begin
				push = accept;
			end
			MODE_TICK: begin
				push_entry.op       = OP_PLAY;
				push_entry.in_range = play_ok;
				push_entry.index    = play_idx;
				if (accept && active) begin
					pos_d = tick_pos;
					push  = play;
				end
			end
			MODE_SET: begin
				if (accept) begin
					pos_d = to_pos(new_position);
				end
			end
			default: begin
				pos_d = pos_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 32'd0;
		end else begin
			pos_q <= pos_d;
		end
	end

endmodule

### rtl/tsv_queue.sv
// ---------------------------------------------------------------------------
// tsv_queue
// short fifo of classified items between front and back end
// ---------------------------------------------------------------------------
module tsv_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tsv_pkg::entry_t  push_entry,
	input  logic             pop,
	output tsv_pkg::entry_t  head,
	output tsv_pkg::qstat_t  qstat
);
	import tsv_pkg::*;

	entry_t            slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign head        = slots_q[rd_ptr_q];
	assign qstat.full  = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/tsv_back.sv
// ---------------------------------------------------------------------------
// tsv_back
// sample memory, volume scaling and the result register
// ---------------------------------------------------------------------------
module tsv_back #(
	parameter int SAMPLE_DEPTH = 16384
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tsv_pkg::cfg_t      cfg,
	input  tsv_pkg::entry_t    head,
	input  tsv_pkg::qstat_t    qstat,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] sample_out,
	output logic [13:0]        sample_index
);
	import tsv_pkg::*;

	localparam int AW = $clog2(SAMPLE_DEPTH);

	logic [15:0]        mem [SAMPLE_DEPTH];
	logic [AW+14:0]     wide_idx;
	logic [AW-1:0]      addr;
	logic               adv;
	logic [13:0]        vol_q;

	logic               valid_s1;
	logic               range_s1;
	logic [14:0]        idx_s1;
	logic [15:0]        rd_s1;

	logic signed [15:0] samp;
	logic signed [30:0] prod;

	logic               valid_s2;
	logic [14:0]        idx_s2;
	logic signed [30:0] prod_s2;

	logic signed [18:0] shr;
	logic signed [15:0] sat;

	logic               result_valid_q;
	logic signed [15:0] sample_out_q;
	logic [13:0]        sample_index_q;

	assign wide_idx = {{AW{1'b0}}, head.index};
	assign addr     = wide_idx[AW-1:0];
	assign adv      = !result_valid_q || !result_stall;
	assign pop      = adv && !qstat.empty;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.op == OP_LOAD) begin
				if (head.in_range) begin
					mem[addr] <= head.data;
				end
			end else begin
				rd_s1 <= mem[addr];
			end
		end
	end

	always_comb begin
		if (!range_s1) begin
			samp = 16'sd0;
		end else if (cfg.wide_samples) begin
			samp = rd_s1;
		end else begin
			samp = {rd_s1[7:0], 8'd0};
		end
		prod = 31'(samp) * 31'($signed({1'b0, vol_q}));
	end

	assign shr = prod_s2[30:12];

	always_comb begin
		priority if (shr > 19'sd32767) begin
			sat = 16'sh7fff;
		end else if (shr < -19'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = shr[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1         <= head.index;
			range_s1       <= head.in_range;
			idx_s2         <= idx_s1;
			prod_s2        <= prod;
			sample_out_q   <= sat;
			sample_index_q <= idx_s2[13:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
			vol_q          <= '0;
		end else begin
			vol_q <= 14'(cfg.channel_volume) * 14'(cfg.instrument_volume);
			if (adv) begin
				valid_s1       <= pop && (head.op == OP_PLAY);
				valid_s2       <= valid_s1;
				result_valid_q <= valid_s2;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign sample_out   = sample_out_q;
	assign sample_index = sample_index_q;

endmodule

### rtl/tsv_checker.sv
// ---------------------------------------------------------------------------
// tsv_checker
// port-level checks on the sample voice, bound to the top level
// ---------------------------------------------------------------------------
`include "tracker_sample_voice_macros.svh"

module tsv_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pready,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [15:0] sample_out,
	input logic [13:0]        sample_index
);

	// a stalled result item stays offered
	`TSV_ASSERT_NEXT(a_result_held, clk, !arst_n, result_valid && result_stall, result_valid)

	// and keeps its payload
	`TSV_ASSERT_NEXT(a_result_stable, clk, !arst_n, result_valid && result_stall, $stable(sample_out) && $stable(sample_index))

	// config access phase never waits
	`TSV_ASSERT_NOW(a_cfg_ready, clk, !arst_n, psel && penable, pready)

	// in the cycle after reset is sampled the queue is not full and no result is offered
	`TSV_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, !arst_n, !item_stall && !result_valid)

endmodule

bind tracker_sample_voice tsv_checker u_tsv_checker (.*);
